### sv/indexed_list_insert_remove_engine_macros.svh
// assertion macros used by the checker of the list engine
`ifndef INDEXED_LIST_INSERT_REMOVE_ENGINE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_ENGINE_MACROS_SVH

// property checked outside reset
`define ILIST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("list engine assertion failed");

// property checked at every edge, reset included
`define ILIST_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("list engine assertion failed");

`endif

### sv/ilist_pkg.sv
package ilist_pkg;

   localparam int DEPTH       = 64;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int ELEM_BITS   = 32;
   localparam int CNT_BITS    = 7;
   localparam int POS_BITS    = 7;
   localparam int KIND_BITS   = 4;
   localparam int STATUS_BITS = 2;

   localparam logic [KIND_BITS-1:0] KIND_APPEND  = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_PREPEND = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_BEFORE  = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_AFTER   = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE  = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_GET     = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_SET     = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_SWAP    = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 4'd8;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_ITEM = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_UNUSED  = 2'd3;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [POS_BITS-1:0]  position;
      logic [POS_BITS-1:0]  other_position;
      logic [ELEM_BITS-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ELEM_BITS-1:0]   read_value;
      logic [CNT_BITS-1:0]    element_count;
   } rsp_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [ELEM_BITS-1:0] wr_data;
      logic [ADDR_BITS-1:0] rd_addr;
   } mem_cmd_type;

endpackage

### sv/ilist_ram.sv
module ilist_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ilist_ctrl.sv
module ilist_ctrl
   import ilist_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CNT_BITS-1:0]  csr_wr_data,
   output mem_cmd_type          mem_cmd,
   input  logic [ELEM_BITS-1:0] mem_rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_PUT,
      ST_SHIFT_DN,
      ST_GET_WAIT,
      ST_SWAP_RD2,
      ST_SWAP_WR1,
      ST_SWAP_WR2,
      ST_DONE
   } state_type;

   state_type                state_ff;
   logic [CNT_BITS-1:0]      count_ff;
   logic [CNT_BITS-1:0]      limit_ff;
   logic [CNT_BITS-1:0]      cursor_ff;
   logic [CNT_BITS-1:0]      target_ff;
   logic [ADDR_BITS-1:0]     pos_ff;
   logic [ADDR_BITS-1:0]     pos2_ff;
   logic [ELEM_BITS-1:0]     value_ff;
   logic                     wpend_ff;
   logic [ADDR_BITS-1:0]     wdst_ff;
   logic [ELEM_BITS-1:0]     swap_ff;
   logic [STATUS_BITS-1:0]   status_ff;
   logic [ELEM_BITS-1:0]     read_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic                accept;
   logic [CNT_BITS-1:0] eff_limit;
   logic                full;
   logic                pos_ok;
   logic                pos2_ok;
   logic [CNT_BITS-1:0] ins_at;
   logic [CNT_BITS-1:0] cur_dec;
   logic [CNT_BITS-1:0] cur_inc;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign eff_limit = (limit_ff == '0 || limit_ff > CNT_BITS'(DEPTH)) ?
                      CNT_BITS'(DEPTH) : limit_ff;
   assign full    = (count_ff >= eff_limit);
   assign pos_ok  = (req_data.position < count_ff);
   assign pos2_ok = (req_data.other_position < count_ff);
   assign cur_dec = cursor_ff - 1'b1;
   assign cur_inc = cursor_ff + 1'b1;

   // slot the new element lands in
   always_comb begin
      case (req_data.kind)
         KIND_PREPEND: ins_at = '0;
         KIND_BEFORE:  ins_at = (req_data.position > count_ff) ? count_ff : req_data.position;
         KIND_AFTER: begin
            if (count_ff == '0) begin
               ins_at = '0;
            end else if (req_data.position >= count_ff) begin
               ins_at = count_ff;
            end else begin
               ins_at = req_data.position + 1'b1;
            end
         end
         default:      ins_at = count_ff;
      endcase
   end

   always_comb begin
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.wr_addr = wdst_ff;
      mem_cmd.wr_data = mem_rd_data;
      mem_cmd.rd_addr = req_data.position[ADDR_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            mem_cmd.wr_en   = accept && (req_data.kind == KIND_SET) && pos_ok;
            mem_cmd.wr_addr = req_data.position[ADDR_BITS-1:0];
            mem_cmd.wr_data = req_data.element_value;
         end
         ST_SHIFT_UP: begin
            mem_cmd.wr_en   = wpend_ff;
            mem_cmd.rd_addr = cur_dec[ADDR_BITS-1:0];
         end
         ST_PUT: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = target_ff[ADDR_BITS-1:0];
            mem_cmd.wr_data = value_ff;
         end
         ST_SHIFT_DN: begin
            mem_cmd.wr_en   = wpend_ff;
            mem_cmd.rd_addr = cur_inc[ADDR_BITS-1:0];
         end
         ST_SWAP_RD2: begin
            mem_cmd.rd_addr = pos2_ff;
         end
         ST_SWAP_WR1: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = pos_ff;
         end
         ST_SWAP_WR2: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = pos2_ff;
            mem_cmd.wr_data = swap_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= '0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  read_ff   <= '0;
                  value_ff  <= req_data.element_value;
                  pos_ff    <= req_data.position[ADDR_BITS-1:0];
                  pos2_ff   <= req_data.other_position[ADDR_BITS-1:0];
                  wpend_ff  <= 1'b0;
                  case (req_data.kind)
                     KIND_APPEND, KIND_PREPEND, KIND_BEFORE, KIND_AFTER: begin
                        if (full) begin
                           status_ff <= STATUS_FULL;
                           state_ff  <= ST_DONE;
                        end else begin
                           status_ff <= STATUS_OK;
                           target_ff <= ins_at;
                           cursor_ff <= count_ff;
                           state_ff  <= ST_SHIFT_UP;
                        end
                     end
                     KIND_REMOVE: begin
                        if (!pos_ok) begin
                           status_ff <= STATUS_NO_ITEM;
                           state_ff  <= ST_DONE;
                        end else begin
                           status_ff <= STATUS_OK;
                           cursor_ff <= req_data.position;
                           state_ff  <= ST_SHIFT_DN;
                        end
                     end
                     KIND_GET: begin
                        if (!pos_ok) begin
                           status_ff <= STATUS_NO_ITEM;
                           state_ff  <= ST_DONE;
                        end else begin
                           status_ff <= STATUS_OK;
                           state_ff  <= ST_GET_WAIT;
                        end
                     end
                     KIND_SET: begin
                        status_ff <= pos_ok ? STATUS_OK : STATUS_NO_ITEM;
                        state_ff  <= ST_DONE;
                     end
                     KIND_SWAP: begin
                        if (!pos_ok || !pos2_ok) begin
                           status_ff <= STATUS_NO_ITEM;
                           state_ff  <= ST_DONE;
                        end else if (req_data.position != req_data.other_position) begin
                           status_ff <= STATUS_OK;
                           state_ff  <= ST_SWAP_RD2;
                        end else begin
                           status_ff <= STATUS_OK;
                           state_ff  <= ST_DONE;
                        end
                     end
                     KIND_CLEAR: begin
                        count_ff  <= '0;
                        status_ff <= STATUS_OK;
                        state_ff  <= ST_DONE;
                     end
                     default: begin
                        status_ff <= STATUS_OK;
                        state_ff  <= ST_DONE;
                     end
                  endcase
               end
            end
            // tail moves up one slot, reading downward one entry ahead of the write
            ST_SHIFT_UP: begin
               if (cursor_ff != target_ff) begin
                  wpend_ff  <= 1'b1;
                  wdst_ff   <= cursor_ff[ADDR_BITS-1:0];
                  cursor_ff <= cur_dec;
               end else begin
                  wpend_ff <= 1'b0;
                  state_ff <= ST_PUT;
               end
            end
            ST_PUT: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= ST_DONE;
            end
            // tail moves down one slot, reading upward one entry ahead of the write
            ST_SHIFT_DN: begin
               if (cur_inc < count_ff) begin
                  wpend_ff  <= 1'b1;
                  wdst_ff   <= cursor_ff[ADDR_BITS-1:0];
                  cursor_ff <= cur_inc;
               end else begin
                  wpend_ff <= 1'b0;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_GET_WAIT: begin
               read_ff  <= mem_rd_data;
               state_ff <= ST_DONE;
            end
            ST_SWAP_RD2: begin
               swap_ff  <= mem_rd_data;
               state_ff <= ST_SWAP_WR1;
            end
            ST_SWAP_WR1: begin
               state_ff <= ST_SWAP_WR2;
            end
            ST_SWAP_WR2: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.status         <= status_ff;
                  rsp_ff.read_value     <= read_ff;
                  rsp_ff.element_count  <= count_ff;
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### sv/indexed_list_insert_remove_engine.sv
// channel  | direction | handshake               | payload
// req      | in        | req_valid / req_ready   | req_type (kind, positions, value)
// rsp      | out       | rsp_valid / rsp_ready   | rsp_type (status, read value, count)
// csr      | in        | csr_wr_en               | csr_wr_data (capacity limit)
//
// one transaction at a time; all elements live in one 64 x 32 ram with a registered read
// insert: the tail moves one entry per cycle, then the new element is written and the count grows
// remove: the tail moves down over the removed entry; get reads one entry, swap reads both then writes both
// reset is synchronous and empties the list; no clearing pass, ram contents are left as is
// a held rsp stalls only the last step; req_ready is low while a transaction is at work
module indexed_list_insert_remove_engine
   import ilist_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [CNT_BITS-1:0] csr_wr_data
);

   mem_cmd_type          mem_cmd;
   logic [ELEM_BITS-1:0] mem_rd_data;

   ilist_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_cmd     (mem_cmd),
      .mem_rd_data (mem_rd_data)
   );

   ilist_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ELEM_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (mem_cmd.wr_data),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

### sv/ilist_checker.sv
`include "indexed_list_insert_remove_engine_macros.svh"

module ilist_checker
   import ilist_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rsp_type             rsp_data
);

   // a stalled response holds
`ILIST_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // no new transaction right after one is taken
`ILIST_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

`ILIST_ASSERT(a_count_bound, clock, reset, rsp_valid |-> rsp_data.element_count <= CNT_BITS'(DEPTH))

   // only a successful response carries data, and the spare status code never shows
`ILIST_ASSERT(a_status_data, clock, reset, rsp_valid |-> rsp_data.status != STATUS_UNUSED && (rsp_data.status == STATUS_OK || rsp_data.read_value == '0))

`ILIST_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind indexed_list_insert_remove_engine ilist_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);
